### rtl/rlf_pkg.sv
// Shared types and constants for the redundant load forwarder.
// Used by rlf_front, rlf_back and the top level; no dependencies.
package rlf_pkg;

    // Instruction kinds on the input stream
    localparam logic [2:0] CMD_BOUNDARY  = 3'd0;
    localparam logic [2:0] CMD_TAKE_ADDR = 3'd1;
    localparam logic [2:0] CMD_STORE     = 3'd2;
    localparam logic [2:0] CMD_LOAD      = 3'd3;

    // Stream widths
    localparam int S_TDATA_BITS = 56;
    localparam int S_TUSER_BITS = 4;
    localparam int M_TDATA_BITS = 16;
    localparam int M_TUSER_BITS = 1;
    localparam int CFG_BITS     = 9;

    localparam logic [CFG_BITS-1:0] SLOT_COUNT_RESET = 9'd256;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Table operation decided by the front
    typedef enum logic [1:0] {
        OP_NOP,
        OP_ESCAPE,
        OP_STORE,
        OP_LOAD
    } op_t;

    // Control part of one queued request
    typedef struct packed {
        op_t  op;
        logic clear;    // all slot tags cleared before this request
    } item_ctl_t;

endpackage

### rtl/rlf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rlf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read old data on a collision
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/rlf_queue.sv
// Small register FIFO that decouples the front from the back.
// No dependencies.
module rlf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full  = (count_reg == FULL_COUNT);
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    // Store on push
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/rlf_front.sv
// Front end: accepts instructions, keeps the epoch and the slot count,
// and turns each instruction into one table request. Uses rlf_pkg.
module rlf_front #(
    parameter int SLOTS      = 256,
    parameter int ADDR_BITS  = 8,
    parameter int VALUE_BITS = 16,
    parameter int EPOCH_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rlf_pkg::S_TDATA_BITS-1:0]    s_tdata,
    input  logic [rlf_pkg::S_TUSER_BITS-1:0]    s_tuser,
    input  logic                                cfg_wr_en,
    input  logic [rlf_pkg::CFG_BITS-1:0]        cfg_wr_data,
    input  logic                                q_ready,
    output logic                                q_push,
    output rlf_pkg::item_ctl_t                  q_ctl,
    output logic [ADDR_BITS-1:0]                q_addr,
    output logic [VALUE_BITS-1:0]               q_value,
    output logic [EPOCH_BITS-1:0]               q_epoch
);
    import rlf_pkg::*;

    localparam logic [16:0] SLOTS_L = 17'(SLOTS);
    localparam logic [EPOCH_BITS-1:0] EPOCH_ONE = EPOCH_BITS'(1);

    logic [CFG_BITS-1:0]   slot_count_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic [EPOCH_BITS-1:0] epoch_next;

    logic [2:0]            cmd;
    logic [15:0]           slot_index;
    logic [15:0]           source_value;
    logic [16:0]           dest_value;
    logic                  first_of_function;

    logic [EPOCH_BITS-1:0] sum1, sum2, epoch1, epoch2;
    logic                  wrap1, wrap2, boundary;
    logic [16:0]           limit;
    logic                  in_range;

    // Unpack the request
    assign cmd               = s_tuser[2:0];
    assign first_of_function = s_tuser[3];
    assign slot_index        = s_tdata[15:0];
    assign source_value      = s_tdata[31:16];
    assign dest_value        = s_tdata[48:32];

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    // Advance the epoch for a new function, then for a boundary
    always_comb begin
        boundary = (cmd == CMD_BOUNDARY);
        sum1     = epoch_reg + EPOCH_ONE;
        wrap1    = first_of_function && (sum1 == '0);
        epoch1   = first_of_function ? ((sum1 == '0) ? EPOCH_ONE : sum1) : epoch_reg;
        sum2     = epoch1 + EPOCH_ONE;
        wrap2    = boundary && (sum2 == '0);
        epoch2   = boundary ? ((sum2 == '0) ? EPOCH_ONE : sum2) : epoch1;
        epoch_next = epoch2;
    end

    // Check the slot against the effective slot count
    always_comb begin
        limit    = ({8'd0, slot_count_reg} < SLOTS_L) ? {8'd0, slot_count_reg} : SLOTS_L;
        in_range = !slot_index[15] && ({1'b0, slot_index} < limit);
    end

    // Classify into a table request
    always_comb begin
        q_ctl.clear = wrap1 || wrap2;
        q_ctl.op    = OP_NOP;
        q_addr      = slot_index[ADDR_BITS-1:0];
        q_value     = VALUE_BITS'(dest_value[15:0]);
        q_epoch     = epoch1;
        if (!boundary && in_range) begin
            case (cmd)
                CMD_TAKE_ADDR: q_ctl.op = OP_ESCAPE;
                CMD_STORE: begin
                    q_ctl.op = OP_STORE;
                    q_value  = VALUE_BITS'(source_value);
                end
                CMD_LOAD: begin
                    // a load without destination does nothing
                    q_ctl.op = dest_value[16] ? OP_NOP : OP_LOAD;
                end
                default: q_ctl.op = OP_NOP;
            endcase
        end
    end

    // Hold the slot count and the epoch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= SLOT_COUNT_RESET;
            epoch_reg      <= EPOCH_ONE;
        end else begin
            if (cfg_wr_en) begin
                slot_count_reg <= cfg_wr_data;
            end
            if (q_push) begin
                epoch_reg <= epoch_next;
            end
        end
    end

endmodule

### rtl/rlf_back.sv
// Back end: read-modify-write of the slot table, one request per cycle while the output
// is not stalled, with a write forward and an output register. Uses rlf_pkg and rlf_ram.
module rlf_back #(
    parameter int DEPTH      = 256,
    parameter int ADDR_BITS  = 8,
    parameter int VALUE_BITS = 16,
    parameter int EPOCH_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  rlf_pkg::item_ctl_t                q_ctl,
    input  logic [ADDR_BITS-1:0]              q_addr,
    input  logic [VALUE_BITS-1:0]             q_value,
    input  logic [EPOCH_BITS-1:0]             q_epoch,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rlf_pkg::M_TDATA_BITS-1:0]  m_tdata,
    output logic [rlf_pkg::M_TUSER_BITS-1:0]  m_tuser
);
    import rlf_pkg::*;

    // Row layout: value, value epoch, escape epoch (low)
    localparam int RW = VALUE_BITS + 2 * EPOCH_BITS;

    logic                  b1_valid_reg;
    item_ctl_t             b1_ctl_reg;
    logic [ADDR_BITS-1:0]  b1_addr_reg;
    logic [VALUE_BITS-1:0] b1_value_reg;
    logic [EPOCH_BITS-1:0] b1_epoch_reg;

    logic [DEPTH-1:0]      row_valid_reg;
    logic [DEPTH-1:0]      row_valid_next;

    logic                  fwd_valid_reg;
    logic [ADDR_BITS-1:0]  fwd_addr_reg;
    logic [RW-1:0]         fwd_row_reg;

    logic                  out_valid_reg;
    logic                  out_copy_reg;
    logic [M_TDATA_BITS-1:0] out_src_reg;

    logic                  b1_fire;
    logic [RW-1:0]         rd_row, cur_row, new_row;
    logic [VALUE_BITS-1:0] row_value;
    logic [EPOCH_BITS-1:0] row_vepoch, row_eepoch;
    logic                  present, escaped, vmatch, wr_en, copy;
    logic [31:0]           value_ext;
    logic [M_TDATA_BITS-1:0] copy_src;

    assign b1_fire = b1_valid_reg && (!out_valid_reg || m_tready);
    assign q_pop   = q_valid && (!b1_valid_reg || b1_fire);

    rlf_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (b1_addr_reg),
        .wdata (new_row),
        .re    (q_pop),
        .raddr (q_addr),
        .rdata (rd_row)
    );

    // Pick the current row: forward the last write, drop cleared tags
    always_comb begin
        cur_row    = (fwd_valid_reg && fwd_addr_reg == b1_addr_reg) ? fwd_row_reg : rd_row;
        present    = row_valid_reg[b1_addr_reg] && !b1_ctl_reg.clear;
        row_value  = cur_row[RW-1 -: VALUE_BITS];
        row_vepoch = present ? cur_row[2*EPOCH_BITS-1 -: EPOCH_BITS] : '0;
        row_eepoch = present ? cur_row[EPOCH_BITS-1:0] : '0;
        escaped    = (row_eepoch == b1_epoch_reg);
        vmatch     = (row_vepoch == b1_epoch_reg);
        value_ext  = 32'(row_value);
    end

    // Decide the table update and the result
    always_comb begin
        wr_en    = 1'b0;
        copy     = 1'b0;
        copy_src = '0;
        new_row  = {row_value, row_vepoch, row_eepoch};
        case (b1_ctl_reg.op)
            OP_ESCAPE: begin
                wr_en   = b1_fire;
                new_row = {row_value, {EPOCH_BITS{1'b0}}, b1_epoch_reg};
            end
            OP_STORE: begin
                wr_en   = b1_fire && !escaped;
                new_row = {b1_value_reg, b1_epoch_reg, row_eepoch};
            end
            OP_LOAD: begin
                if (!escaped && vmatch) begin
                    copy     = 1'b1;
                    copy_src = value_ext[M_TDATA_BITS-1:0];
                end else begin
                    wr_en   = b1_fire && !escaped;
                    new_row = {b1_value_reg, b1_epoch_reg, row_eepoch};
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Clear all tags on an epoch wrap, then mark the written row
    always_comb begin
        row_valid_next = row_valid_reg;
        if (b1_fire && b1_ctl_reg.clear) begin
            row_valid_next = '0;
        end
        if (wr_en) begin
            row_valid_next[b1_addr_reg] = 1'b1;
        end
    end

    // Advance the lookup stage and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
            if (q_pop) begin
                b1_valid_reg <= 1'b1;
            end else if (b1_fire) begin
                b1_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                fwd_valid_reg <= 1'b1;
            end
            if (b1_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b1_ctl_reg   <= q_ctl;
            b1_addr_reg  <= q_addr;
            b1_value_reg <= q_value;
            b1_epoch_reg <= q_epoch;
        end
        if (wr_en) begin
            fwd_addr_reg <= b1_addr_reg;
            fwd_row_reg  <= new_row;
        end
        if (b1_fire) begin
            out_copy_reg <= copy;
            out_src_reg  <= copy_src;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_src_reg;
    assign m_tuser  = out_copy_reg;

endmodule

### rtl/redundant_load_forwarder_unit.sv
// Redundant load forwarder: top level with front, queue and table back end.
// Uses rlf_pkg, rlf_front, rlf_queue and rlf_back.
//
// Takes one instruction per cycle while the queue has room and returns one
// result per instruction, in order: make_copy is set when a load can be
// replaced by a copy of the slot's last known value, given in copy_source.
// Sustained rate is one instruction per clock when the output does not
// stall; this is set by the slot table, a single memory read and write per
// instruction with a one-entry write forward. With an empty queue and no
// output stall, the request enters the queue when the input is accepted, is
// read from the table as it leaves the queue into the lookup stage, and its
// update lands in the output register. A four-entry queue sits between the
// front, which tracks the epoch and range-checks the slot, and the table back
// end, so each side can stall on its own. There is no clearing pass after
// reset: per-slot tag valid bits clear at once on reset and on an epoch wrap.
// slot_count may be written only while the block is idle.
module redundant_load_forwarder_unit #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 16,
    parameter int EPOCH_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // slot_index[15:0], source_value[31:16], dest_value[48:32], zero pad
    input  logic [rlf_pkg::S_TDATA_BITS-1:0] s_tdata,
    // cmd[2:0], first_of_function[3]
    input  logic [rlf_pkg::S_TUSER_BITS-1:0] s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // copy_source[15:0]
    output logic [rlf_pkg::M_TDATA_BITS-1:0] m_tdata,
    // make_copy[0]
    output logic [rlf_pkg::M_TUSER_BITS-1:0] m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [rlf_pkg::CFG_BITS-1:0]     cfg_wr_data
);
    import rlf_pkg::*;

    // Slots above the largest slot_count are never addressed
    localparam int DEPTH     = (SLOTS < 512) ? SLOTS : 512;
    localparam int ADDR_BITS = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int CTL_BITS  = $bits(item_ctl_t);
    localparam int QW        = CTL_BITS + ADDR_BITS + VALUE_BITS + EPOCH_BITS;

    logic                  f_push;
    item_ctl_t             f_ctl;
    logic [ADDR_BITS-1:0]  f_addr;
    logic [VALUE_BITS-1:0] f_value;
    logic [EPOCH_BITS-1:0] f_epoch;

    logic                  q_full, q_empty, q_pop;
    logic [QW-1:0]         q_dout;
    item_ctl_t             q_ctl;
    logic [ADDR_BITS-1:0]  q_addr;
    logic [VALUE_BITS-1:0] q_value;
    logic [EPOCH_BITS-1:0] q_epoch;

    rlf_front #(
        .SLOTS      (SLOTS),
        .ADDR_BITS  (ADDR_BITS),
        .VALUE_BITS (VALUE_BITS),
        .EPOCH_BITS (EPOCH_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_ready     (!q_full),
        .q_push      (f_push),
        .q_ctl       (f_ctl),
        .q_addr      (f_addr),
        .q_value     (f_value),
        .q_epoch     (f_epoch)
    );

    rlf_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_push),
        .din     ({f_ctl, f_addr, f_value, f_epoch}),
        .pop     (q_pop),
        .dout    (q_dout),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign {q_ctl, q_addr, q_value, q_epoch} = q_dout;

    rlf_back #(
        .DEPTH      (DEPTH),
        .ADDR_BITS  (ADDR_BITS),
        .VALUE_BITS (VALUE_BITS),
        .EPOCH_BITS (EPOCH_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (!q_empty),
        .q_pop    (q_pop),
        .q_ctl    (q_ctl),
        .q_addr   (q_addr),
        .q_value  (q_value),
        .q_epoch  (q_epoch),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // Queued requests always carry a live epoch, never the cleared tag
    a_epoch_live: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_empty |-> q_epoch != '0)
        else $error("queued request with zero epoch");

    // A result that is not a copy reads no value
    a_no_copy_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("copy_source set without make_copy");

    // Pop only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // No result is shown right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule
